@@ hdl/kpq_pkg.sv @@
package kpq_pkg;
    localparam int unsigned MaxItemsDefault  = 1024;
    localparam int unsigned CutoffDefault    = 7;
    localparam int unsigned StackDepthDefault = 20;
    localparam int unsigned DataW = 32;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOP,
        // insertion sort
        ST_INS_J,
        ST_INS_JRD,
        ST_INS_IRD,
        ST_INS_CMP,
        ST_INS_PUT,
        // median of three and partition
        ST_MED_RD,
        ST_MED_SW1,
        ST_SWP_RD,
        ST_SWP_WR,
        ST_MED_C1,
        ST_MED_C2,
        ST_MED_C3,
        ST_PIV_RD,
        ST_SCAN_I,
        ST_SCAN_IC,
        ST_SCAN_J,
        ST_SCAN_JC,
        ST_FIN_RD,
        ST_FIN_WR,
        ST_PUSH,
        ST_POP,
        ST_FETCH_RD,
        ST_OUT
    } state_t;
endpackage

@@ hdl/keyed_pair_quicksort.sv @@
// Keyed pair quicksort. Load items (operation 0) store a signed key and its
// value; loads beyond MAX_ITEMS are dropped. A load with last set sorts the
// batch ascending by key with median-of-three quicksort, insertion sort for
// short subranges, smaller part first, larger part pushed on a range stack.
// While sorting s_ready is low. Fetch items (operation 1) return the next
// pair, last_out on the final one, empty_out when none is left. Pairs live in
// one 64-bit wide single-port-read RAM (key and value side by side), the
// range stack in a second small RAM. Each memory read returns registered
// data, so a fetch reads its pair in ST_FETCH_RD before the result shows,
// while a fetch with nothing left shows the empty result directly. In the
// sort, each key compare waits for a memory read and a pair swap reads both
// pairs and writes them back. A load after a finished sort starts a new
// batch. No clearing pass is needed after reset.
module keyed_pair_quicksort
    import kpq_pkg::*;
#(
    parameter int unsigned MAX_ITEMS        = MaxItemsDefault,
    parameter int unsigned INSERTION_CUTOFF = CutoffDefault,
    parameter int unsigned STACK_DEPTH      = StackDepthDefault
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic signed [DataW-1:0] s_key_in,
    input  logic signed [DataW-1:0] s_value_in,
    input  logic                    s_last_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [DataW-1:0] m_key_out,
    output logic signed [DataW-1:0] m_value_out,
    output logic                    m_last_out,
    output logic                    m_empty_out
);
    // positions are 1-based in the model; here 0-based address = pos - 1,
    // indices kept 1-based with one spare bit for underflow/overflow compares
    localparam int unsigned AW  = $clog2(MAX_ITEMS);
    localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned IW  = CW + 1;          // index width (holds 0..MAX+1)
    localparam int unsigned SAW = $clog2(STACK_DEPTH);
    localparam int unsigned TW  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned PW  = 2 * DataW;

    state_t st_reg, st_next;
    state_t ret_reg, ret_next;       // return state after a swap

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rdptr_reg, rdptr_next;
    logic          sorted_reg, sorted_next;

    logic [IW-1:0] l_reg, l_next, r_reg, r_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next;
    logic [IW-1:0] jj_reg, jj_next;   // insertion outer index
    logic [IW-1:0] x_reg, x_next, y_reg, y_next;  // swap addresses
    logic [TW-1:0] top_reg, top_next;
    logic [PW-1:0] a_reg, a_next;     // held pair (pivot or insertion key)
    logic [PW-1:0] t_reg, t_next;     // temp pair
    logic [1:0]    ph_reg, ph_next;   // sub-phase counter
    logic [IW-1:0] il_reg, il_next, ir_reg, ir_next;  // insertion bounds
    state_t        iret_reg, iret_next;               // after insertion

    logic            m_valid_reg, m_valid_next;
    logic [PW-1:0]   mout_reg, mout_next;
    logic            mlast_reg, mlast_next, mempty_reg, mempty_next;

    // pair memory
    logic          pwe;
    logic [IW-1:0] pwidx, pridx;
    logic [PW-1:0] pwdata, prdata;
    // stack memory
    logic          swe;
    logic [TW-1:0] swidx, sridx;
    logic [IW-1:0] swdata, srdata;

    kpq_ram #(.WIDTH(PW), .DEPTH(MAX_ITEMS)) u_pair_ram (
        .aclk (aclk),
        .we   (pwe),
        .waddr(AW'(pwidx - IW'(1))),
        .wdata(pwdata),
        .raddr(AW'(pridx - IW'(1))),
        .rdata(prdata)
    );

    kpq_ram #(.WIDTH(IW), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .aclk (aclk),
        .we   (swe),
        .waddr(SAW'(swidx)),
        .wdata(swdata),
        .raddr(SAW'(sridx)),
        .rdata(srdata)
    );

    function automatic logic key_gt(logic [PW-1:0] p, logic [PW-1:0] q);
        return $signed(p[PW-1:DataW]) > $signed(q[PW-1:DataW]);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            count_reg   <= '0;
            rdptr_reg   <= '0;
            sorted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            count_reg   <= count_next;
            rdptr_reg   <= rdptr_next;
            sorted_reg  <= sorted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg  <= ret_next;
        iret_reg <= iret_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        jj_reg   <= jj_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        top_reg  <= top_next;
        a_reg    <= a_next;
        t_reg    <= t_next;
        ph_reg   <= ph_next;
        il_reg   <= il_next;
        ir_reg   <= ir_next;
        mout_reg <= mout_next;
        mlast_reg  <= mlast_next;
        mempty_reg <= mempty_next;
    end

    logic [IW-1:0] rsz, lsz;
    assign rsz = r_reg - i_reg + IW'(1);
    assign lsz = j_reg - l_reg;

    always_comb begin
        st_next = st_reg;   ret_next = ret_reg;   iret_next = iret_reg;
        count_next = count_reg; rdptr_next = rdptr_reg; sorted_next = sorted_reg;
        l_next = l_reg; r_next = r_reg; i_next = i_reg; j_next = j_reg;
        jj_next = jj_reg; x_next = x_reg; y_next = y_reg; top_next = top_reg;
        a_next = a_reg; t_next = t_reg; ph_next = ph_reg;
        il_next = il_reg; ir_next = ir_reg;
        m_valid_next = m_valid_reg; mout_next = mout_reg;
        mlast_next = mlast_reg; mempty_next = mempty_reg;
        pwe = 1'b0; pwidx = IW'(1); pwdata = t_reg; pridx = IW'(1);
        swe = 1'b0; swidx = '0; swdata = '0; sridx = '0;
        s_ready = 1'b0;

        case (st_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == OP_LOAD) begin
                        logic [CW-1:0] c;
                        c = sorted_reg ? '0 : count_reg;
                        if (sorted_reg) begin
                            rdptr_next  = '0;
                            sorted_next = 1'b0;
                        end
                        if (IW'(c) < IW'(MAX_ITEMS)) begin
                            c = c + CW'(1);
                            pwe    = 1'b1;
                            pwidx  = IW'(c);
                            pwdata = {s_key_in, s_value_in};
                        end
                        count_next = c;
                        if (s_last_in) begin
                            sorted_next = 1'b1;
                            rdptr_next  = '0;
                            l_next   = IW'(1);
                            r_next   = IW'(c);
                            top_next = '0;
                            if (IW'(c) >= IW'(2)) st_next = ST_LOOP;
                        end
                    end else if (sorted_reg && rdptr_reg < count_reg) begin
                        pridx   = IW'(rdptr_reg) + IW'(1);
                        st_next = ST_FETCH_RD;
                    end else begin
                        mout_next = '0; mlast_next = 1'b0; mempty_next = 1'b1;
                        m_valid_next = 1'b1;
                        st_next = ST_OUT;
                    end
                end
            end
            ST_FETCH_RD: begin
                mout_next   = prdata;
                mlast_next  = (rdptr_reg + CW'(1)) == count_reg;
                mempty_next = 1'b0;
                rdptr_next  = rdptr_reg + CW'(1);
                m_valid_next = 1'b1;
                st_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    st_next = ST_IDLE;
                end
            end
            ST_LOOP: begin
                if (r_reg - l_reg < IW'(INSERTION_CUTOFF)) begin
                    il_next = l_reg; ir_next = r_reg;
                    jj_next = l_reg + IW'(1);
                    iret_next = ST_POP;
                    st_next = ST_INS_J;
                end else begin
                    // swap (k, l+1)
                    x_next = (l_reg + r_reg) >> 1;
                    y_next = l_reg + IW'(1);
                    ret_next = ST_MED_C1;
                    ph_next = 2'd0;
                    st_next = ST_SWP_RD;
                end
            end
            ST_POP: begin
                if (top_reg == '0) begin
                    st_next = ST_IDLE;
                end else begin
                    // read of r, then l, from the stack top
                    case (ph_reg)
                        2'd0: begin
                            sridx = top_reg - TW'(1);
                            ph_next = 2'd1;
                        end
                        2'd1: begin
                            r_next = srdata;
                            sridx = top_reg - TW'(2);
                            ph_next = 2'd2;
                        end
                        default: begin
                            l_next = srdata;
                            top_next = top_reg - TW'(2);
                            ph_next = 2'd0;
                            st_next = ST_LOOP;
                        end
                    endcase
                end
            end
            // generic pair swap of x and y
            ST_SWP_RD: begin
                case (ph_reg)
                    2'd0: begin pridx = x_reg; ph_next = 2'd1; end
                    2'd1: begin t_next = prdata; pridx = y_reg; ph_next = 2'd2; end
                    default: begin
                        pwe = 1'b1; pwidx = x_reg; pwdata = prdata;
                        ph_next = 2'd0;
                        st_next = ST_SWP_WR;
                    end
                endcase
            end
            ST_SWP_WR: begin
                pwe = 1'b1; pwidx = y_reg; pwdata = t_reg;
                st_next = ret_reg;
            end
            // compare two entries, swap if first key greater
            ST_MED_C1, ST_MED_C2, ST_MED_C3: begin
                logic [IW-1:0] p, q;
                state_t nx;
                p = l_reg + IW'(1); q = r_reg; nx = ST_MED_C2;
                if (st_reg == ST_MED_C2) begin p = l_reg; nx = ST_MED_C3; end
                if (st_reg == ST_MED_C3) begin
                    p = l_reg + IW'(1); q = l_reg; nx = ST_PIV_RD;
                end
                case (ph_reg)
                    2'd0: begin pridx = p; ph_next = 2'd1; end
                    2'd1: begin t_next = prdata; pridx = q; ph_next = 2'd2; end
                    default: begin
                        ph_next = 2'd0;
                        if (key_gt(t_reg, prdata)) begin
                            x_next = p; y_next = q; ret_next = nx;
                            st_next = ST_SWP_RD;
                        end else begin
                            st_next = nx;
                        end
                    end
                endcase
            end
            ST_PIV_RD: begin
                if (ph_reg == 2'd0) begin
                    pridx = l_reg; ph_next = 2'd1;
                end else begin
                    a_next = prdata; ph_next = 2'd0;
                    i_next = l_reg + IW'(1); j_next = r_reg;
                    st_next = ST_SCAN_I;
                end
            end
            ST_SCAN_I: begin
                i_next = i_reg + IW'(1);
                if (i_reg + IW'(1) < r_reg) begin
                    pridx = i_reg + IW'(1);
                    st_next = ST_SCAN_IC;
                end else begin
                    st_next = ST_SCAN_J;
                end
            end
            ST_SCAN_IC: begin
                st_next = key_gt(a_reg, prdata) ? ST_SCAN_I : ST_SCAN_J;
            end
            ST_SCAN_J: begin
                j_next = j_reg - IW'(1);
                if (j_reg - IW'(1) > l_reg) begin
                    pridx = j_reg - IW'(1);
                    st_next = ST_SCAN_JC;
                end else if (j_reg - IW'(1) < i_reg) begin
                    st_next = ST_FIN_RD;
                end else begin
                    x_next = i_reg; y_next = j_reg - IW'(1);
                    ret_next = ST_SCAN_I; st_next = ST_SWP_RD;
                end
            end
            ST_SCAN_JC: begin
                if (key_gt(prdata, a_reg)) begin
                    st_next = ST_SCAN_J;
                end else if (j_reg < i_reg) begin
                    st_next = ST_FIN_RD;
                end else begin
                    x_next = i_reg; y_next = j_reg;
                    ret_next = ST_SCAN_I; st_next = ST_SWP_RD;
                end
            end
            ST_FIN_RD: begin
                if (ph_reg == 2'd0) begin
                    pridx = j_reg; ph_next = 2'd1;
                end else begin
                    pwe = 1'b1; pwidx = l_reg; pwdata = prdata;
                    ph_next = 2'd0;
                    st_next = ST_FIN_WR;
                end
            end
            ST_FIN_WR: begin
                pwe = 1'b1; pwidx = j_reg; pwdata = a_reg;
                st_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (IW'(top_reg) + IW'(2) > IW'(STACK_DEPTH)) begin
                    if (rsz > lsz) begin
                        il_next = i_reg; ir_next = r_reg;
                        r_next = j_reg - IW'(1);
                    end else begin
                        il_next = l_reg; ir_next = j_reg - IW'(1);
                        l_next = i_reg;
                    end
                    jj_next = (rsz > lsz) ? i_reg + IW'(1) : l_reg + IW'(1);
                    iret_next = ST_LOOP;
                    st_next = ST_INS_J;
                end else if (ph_reg == 2'd0) begin
                    swe = 1'b1; swidx = top_reg;
                    swdata = (rsz > lsz) ? i_reg : l_reg;
                    ph_next = 2'd1;
                end else begin
                    swe = 1'b1; swidx = top_reg + TW'(1);
                    swdata = (rsz > lsz) ? r_reg : j_reg - IW'(1);
                    top_next = top_reg + TW'(2);
                    if (rsz > lsz) r_next = j_reg - IW'(1);
                    else l_next = i_reg;
                    ph_next = 2'd0;
                    st_next = ST_LOOP;
                end
            end
            // insertion sort over [il, ir], outer index jj
            ST_INS_J: begin
                if (jj_reg > ir_reg) begin
                    st_next = iret_reg;
                end else begin
                    pridx = jj_reg;
                    st_next = ST_INS_JRD;
                end
            end
            ST_INS_JRD: begin
                a_next = prdata;
                i_next = jj_reg - IW'(1);
                st_next = ST_INS_IRD;
            end
            ST_INS_IRD: begin
                if (i_reg >= il_reg && i_reg != '0) begin
                    pridx = i_reg;
                    st_next = ST_INS_CMP;
                end else begin
                    st_next = ST_INS_PUT;
                end
            end
            ST_INS_CMP: begin
                if (key_gt(prdata, a_reg)) begin
                    pwe = 1'b1; pwidx = i_reg + IW'(1); pwdata = prdata;
                    i_next = i_reg - IW'(1);
                    st_next = ST_INS_IRD;
                end else begin
                    st_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                pwe = 1'b1; pwidx = i_reg + IW'(1); pwdata = a_reg;
                jj_next = jj_reg + IW'(1);
                st_next = ST_INS_J;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_key_out   = mout_reg[PW-1:DataW];
    assign m_value_out = mout_reg[DataW-1:0];
    assign m_last_out  = mlast_reg;
    assign m_empty_out = mempty_reg;
endmodule

@@ hdl/kpq_ram.sv @@
module kpq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/kpq_checker.sv @@
module kpq_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_operation,
    input logic m_valid,
    input logic m_ready,
    input logic m_last_out,
    input logic m_empty_out
);
    import kpq_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_empty_out))
        else $error("result dropped while stalled");

    // no new item taken while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken with result pending");

    // a fetch is followed by a result
    a_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_FETCH |=> ##1 m_valid || $past(m_valid))
        else $error("fetch without result");

    // empty and last never together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_empty_out && m_last_out))
        else $error("empty and last both set");
endmodule

bind keyed_pair_quicksort kpq_checker u_kpq_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_operation(s_operation),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_last_out (m_last_out),
    .m_empty_out(m_empty_out)
);

@@ test/tb_top.sv @@
module tb_top;
    import kpq_pkg::*;

    localparam int unsigned Capacity = MaxItemsDefault;

    // one input item
    typedef struct packed {
        op_t                      op;
        logic signed [DataW-1:0]  key;
        logic signed [DataW-1:0]  value;
        logic                     last;
    } cmd_t;

    // one fetch result
    typedef struct packed {
        logic signed [DataW-1:0]  key;
        logic signed [DataW-1:0]  value;
        logic                     last;
        logic                     empty;
    } pair_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_operation;
    logic signed [DataW-1:0] s_key_in;
    logic signed [DataW-1:0] s_value_in;
    logic                    s_last_in;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [DataW-1:0] m_key_out;
    logic signed [DataW-1:0] m_value_out;
    logic                    m_last_out;
    logic                    m_empty_out;

    keyed_pair_quicksort DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_key_in    (s_key_in),
        .s_value_in  (s_value_in),
        .s_last_in   (s_last_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_key_out   (m_key_out),
        .m_value_out (m_value_out),
        .m_last_out  (m_last_out),
        .m_empty_out (m_empty_out)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // --------------------------------------------------------------------
    // Sorting predictor: a private copy of the pair store and range stack,
    // running the same quicksort so that equal keys land in the same order.
    // Index 0 is a spare slot; pairs live at 1..count.
    // --------------------------------------------------------------------
    logic signed [DataW-1:0] pk [0:Capacity+1];
    logic signed [DataW-1:0] pv [0:Capacity+1];
    int unsigned             rstack [0:StackDepthDefault+1];
    int unsigned             pair_count = 0;
    int unsigned             next_out = 0;
    bit                      is_sorted = 0;

    pair_t fetch_results[$];   // results still owed by the block
    cmd_t  pending[$];         // items waiting for the driver
    int    errors = 0;
    bit    quiet;              // last part of the run: no idling

    function automatic int unsigned slot(int unsigned x);
        return (x <= Capacity + 1) ? x : 0;
    endfunction

    function automatic void swap_slots(int unsigned x, int unsigned y);
        logic signed [DataW-1:0] t;
        x = slot(x);
        y = slot(y);
        t = pk[x]; pk[x] = pk[y]; pk[y] = t;
        t = pv[x]; pv[x] = pv[y]; pv[y] = t;
    endfunction

    // insertion sort of [l, r]; unsigned wrap below l ends the scan as in the file
    function automatic void insert_sort(int unsigned l, int unsigned r);
        int unsigned             i, j;
        logic signed [DataW-1:0] a, b;
        for (j = l + 1; j <= r; j++) begin
            a = pk[slot(j)];
            b = pv[slot(j)];
            i = j - 1;
            while (i >= l && pk[slot(i)] > a) begin
                pk[slot(i + 1)] = pk[slot(i)];
                pv[slot(i + 1)] = pv[slot(i)];
                i--;
            end
            pk[slot(i + 1)] = a;
            pv[slot(i + 1)] = b;
        end
    endfunction

    function automatic void quicksort_pairs(int unsigned n);
        int unsigned             l, r, i, j, k, top;
        logic signed [DataW-1:0] a, b;
        l = 1;
        r = n;
        top = 0;
        if (n < 2) return;
        forever begin
            if (r - l < CutoffDefault) begin
                insert_sort(l, r);
                if (top == 0) break;
                r = rstack[top];
                l = rstack[top - 1];
                top -= 2;
                continue;
            end
            // median of three into l, with l+1 <= l <= r by key
            k = (l + r) >> 1;
            swap_slots(k, l + 1);
            if (pk[slot(l + 1)] > pk[slot(r)]) swap_slots(l + 1, r);
            if (pk[slot(l)] > pk[slot(r)]) swap_slots(l, r);
            if (pk[slot(l + 1)] > pk[slot(l)]) swap_slots(l + 1, l);
            i = l + 1;
            j = r;
            a = pk[slot(l)];
            b = pv[slot(l)];
            forever begin
                do i++; while (i < r && pk[slot(i)] < a);
                do j--; while (j > l && pk[slot(j)] > a);
                if (j < i) break;
                swap_slots(i, j);
            end
            pk[slot(l)] = pk[slot(j)];
            pk[slot(j)] = a;
            pv[slot(l)] = pv[slot(j)];
            pv[slot(j)] = b;
            if (top + 2 > StackDepthDefault) begin
                if (r - i + 1 > j - l) begin
                    insert_sort(i, r);
                    r = j - 1;
                end else begin
                    insert_sort(l, j - 1);
                    l = i;
                end
                continue;
            end
            // push the larger part, go on with the smaller
            top += 2;
            if (r - i + 1 > j - l) begin
                rstack[top] = r;
                rstack[top - 1] = i;
                r = j - 1;
            end else begin
                rstack[top] = j - 1;
                rstack[top - 1] = l;
                l = i;
            end
        end
    endfunction

    // apply one accepted item to the predictor, queue any fetch result
    function automatic void predict_sorter(cmd_t c);
        pair_t p;
        if (c.op == OP_LOAD) begin
            if (is_sorted) begin
                pair_count = 0;
                next_out = 0;
                is_sorted = 0;
            end
            if (pair_count < Capacity) begin
                pair_count++;
                pk[slot(pair_count)] = c.key;
                pv[slot(pair_count)] = c.value;
            end
            if (c.last) begin
                quicksort_pairs(pair_count);
                is_sorted = 1;
                next_out = 0;
            end
        end else begin
            p = '0;
            if (is_sorted && next_out < pair_count) begin
                p.key = pk[slot(next_out + 1)];
                p.value = pv[slot(next_out + 1)];
                p.last = (next_out + 1 == pair_count);
                next_out++;
            end else begin
                p.empty = 1'b1;
            end
            fetch_results.push_back(p);
        end
    endfunction

    // --------------------------------------------------------------------
    // Driver: offers queued items, random idle bursts between them.
    // A hold flag lets the stimulus pause the sender while it queues items.
    // --------------------------------------------------------------------
    int unsigned src_gap;
    bit          src_hold;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_operation <= OP_LOAD;
            s_key_in    <= '0;
            s_value_in  <= '0;
            s_last_in   <= 1'b0;
            src_gap     <= 0;
        end else begin
            if (s_valid && s_ready) predict_sorter({op_t'(s_operation), s_key_in,
                                                    s_value_in, s_last_in});
            if (!s_valid || s_ready) begin
                // current item done (or none): maybe idle, else load next
                if (src_gap != 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pending.size() != 0 && !src_hold
                             && (quiet || $urandom_range(0, 9) != 0)) begin
                    cmd_t c;
                    c = pending.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= c.op;
                    s_key_in    <= c.key;
                    s_value_in  <= c.value;
                    s_last_in   <= c.last;
                end else begin
                    s_valid <= 1'b0;
                    if (!quiet && $urandom_range(0, 19) == 0)
                        src_gap <= $urandom_range(1, 19);
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // Long receiver stall: once requested, holds off from the first waiting
    // result for a fixed stretch while the sender keeps offering items.
    // --------------------------------------------------------------------
    bit          stall_req;
    bit          stall_done;
    int unsigned stall_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_done <= 1'b0;
            stall_left <= 0;
        end else if (stall_req && !stall_done && m_valid) begin
            stall_done <= 1'b1;
            stall_left <= 300;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // --------------------------------------------------------------------
    // Monitor: checks each fetch result against the oldest expectation.
    // Receiver stalls come in bursts; the long stall above also holds it.
    // --------------------------------------------------------------------
    int unsigned sink_gap;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (fetch_results.size() == 0) begin
                    $display("%0t: unexpected result key=%0d value=%0d last=%0b empty=%0b",
                             $time, m_key_out, m_value_out, m_last_out, m_empty_out);
                    errors++;
                end else begin
                    pair_t e;
                    e = fetch_results.pop_front();
                    if (m_key_out !== e.key) begin
                        $display("%0t: key_out expected %0d actual %0d",
                                 $time, e.key, m_key_out);
                        errors++;
                    end
                    if (m_value_out !== e.value) begin
                        $display("%0t: value_out expected %0d actual %0d",
                                 $time, e.value, m_value_out);
                        errors++;
                    end
                    if (m_last_out !== e.last) begin
                        $display("%0t: last_out expected %0b actual %0b",
                                 $time, e.last, m_last_out);
                        errors++;
                    end
                    if (m_empty_out !== e.empty) begin
                        $display("%0t: empty_out expected %0b actual %0b",
                                 $time, e.empty, m_empty_out);
                        errors++;
                    end
                end
            end
            if (stall_left != 0 || (stall_req && !stall_done)) begin
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                m_ready  <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else if (!quiet && $urandom_range(0, 14) == 0) begin
                m_ready  <= 1'b0;
                sink_gap <= $urandom_range(0, 18);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // --------------------------------------------------------------------
    // Stimulus helpers
    // --------------------------------------------------------------------
    function automatic logic signed [DataW-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            3: return -32'sd1;
            4: return $signed($urandom_range(0, 15)) - 8;   // many duplicates
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_load(logic signed [DataW-1:0] k, logic signed [DataW-1:0] v,
                              logic lst);
        pending.push_back({OP_LOAD, k, v, lst});
    endtask

    task automatic queue_fetch();
        // key/value/last are don't-care on a fetch; fill with noise
        pending.push_back({OP_FETCH, DataW'($urandom()), DataW'($urandom()),
                           1'($urandom())});
    endtask

    // one batch: n loads (last on the final one), then a number of fetches
    task automatic queue_batch(int unsigned n, int unsigned fetches, bit sorted_in);
        int unsigned i;
        logic signed [DataW-1:0] k;
        for (i = 0; i < n; i++) begin
            k = sorted_in ? $signed(i) - 100 : rand_word();
            queue_load(k, $urandom(), i == n - 1);
        end
        for (i = 0; i < fetches; i++) queue_fetch();
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || s_valid || fetch_results.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int unsigned n, i;
        quiet      = 0;
        src_hold   = 0;
        stall_req  = 0;
        aresetn     = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: fetch before any sort, single item, extremes, duplicates
        queue_fetch();
        queue_load(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
        queue_fetch();
        queue_fetch();
        queue_load(32'sh7fff_ffff, 1, 1'b0);
        queue_load(32'sh8000_0000, 2, 1'b0);
        queue_load(0, 32'sh7fff_ffff, 1'b0);
        queue_load(-1, -1, 1'b0);
        queue_load(5, 3, 1'b0);
        queue_load(5, 4, 1'b0);
        queue_load(5, 5, 1'b0);
        queue_load(32'sh8000_0000, 6, 1'b0);
        queue_load(1, 7, 1'b1);
        for (i = 0; i < 10; i++) queue_fetch();
        wait_drained();

        // long receiver stall once results wait, so the block stalls its input
        // while the sender keeps offering items
        stall_req = 1;
        queue_batch(40, 41, 0);
        wait_drained();

        // full store: loads past capacity dropped, last still sorts
        src_hold = 1;
        for (i = 0; i < Capacity + 3; i++)
            queue_load(rand_word(), $urandom(), i == Capacity + 2);
        src_hold = 0;
        for (i = 0; i < 12; i++) queue_fetch();
        // a load mid-readout starts a new batch
        queue_batch(3, 4, 1);
        wait_drained();

        // random batches: mostly well formed, some partial readouts
        n = 0;
        while (n < 350) begin
            int unsigned sz, fc;
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                             : $urandom_range(1, 14);
            fc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, sz + 2) : sz + 1;
            queue_batch(sz, fc, $urandom_range(0, 9) == 0);
            n += sz + fc;
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
        wait_drained();

        // tail: no idling on either side
        quiet = 1;
        queue_batch(30, 31, 0);
        wait_drained();
        repeat (50) @(posedge aclk);

        if (errors == 0) begin
            $display("keyed_pair_quicksort verification clean");
        end else begin
            $display("keyed_pair_quicksort verification failed");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("keyed_pair_quicksort verification failed");
        $finish;
    end

endmodule
